/* hw/rtl/stall_detect_homing_defines.svh */
// assertion macros used by the stall detector top level
`ifndef STALL_DETECT_HOMING_DEFINES_SVH
`define STALL_DETECT_HOMING_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdh same-cycle check failed");

// next-cycle implication, checked outside reset
`define SDH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdh next-cycle check failed");

`endif

/* hw/rtl/sdh_pkg.sv */
// types, codes and constants of the stall detector
`default_nettype none
package sdh_pkg;

    // request selector codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_IGNORE_WINDOW   = 3'd0;
    localparam logic [2:0] REG_POLL_INTERVAL   = 3'd1;
    localparam logic [2:0] REG_BASELINE_WINDOW = 3'd2;
    localparam logic [2:0] REG_KEEP_FRACTION   = 3'd3;
    localparam logic [2:0] REG_ABS_THRESHOLD   = 3'd4;
    localparam logic [2:0] REG_MIN_STALL_STEPS = 3'd5;

    localparam logic [8:0]  KEEP_RESET     = 9'd128;
    localparam logic [15:0] SAMPLES_NEEDED = 16'd5;
    localparam logic [15:0] EARLY_FOLLOW   = 16'd3;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam int          DIV_STEPS      = 16;
    localparam int          DIV_CNT_W      = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        now_ms;
        logic [9:0]         load_raw;
        logic signed [31:0] position_steps;
    } in_item_t;

    typedef struct packed {
        logic        stall_res;
        logic        homing_active;
        logic        homing_done;
        logic [15:0] baseline_level;
        logic [15:0] average_level;
    } out_item_t;

    typedef struct packed {
        logic [15:0] ignore_window_ms;
        logic [15:0] poll_interval_ms;
        logic [15:0] baseline_window_ms;
        logic [8:0]  keep_fraction;
        logic [9:0]  absolute_threshold;
        logic [23:0] min_stall_steps;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_DEND,
        ST_THR,
        ST_JUDGE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic div_init;
        logic div_step;
        logic div_end;
        logic thr;
        logic judge;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_go;      // tick request while homing is active
        logic base_sample;  // new sample lands inside the baseline window
    } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/stall_detect_homing.sv */
// top level of the sensorless-homing stall detector
//
//  channel | ports                                | moves
//  --------+--------------------------------------+-------------------------------
//  input   | s_valid s_ready s_data               | start, tick or clear request
//  result  | m_valid m_ready m_data               | stall flag, homing flags, levels
//  config  | cfg_valid cfg_ready cfg_index cfg_data| one register write per request
//
// one request at a time; a result sits in the output register while the next
// request is taken in
// start, clear and ignored ticks pass from the execute state to the result state
// a tick without a baseline sample goes through threshold and judge; one with
// a sample runs the multiply and the 16-step restoring divider for the running mean
// synchronous active-low reset clears all homing state; keep_fraction resets to 128
// a stalled result holds the last step of the sequencer until the register frees
`default_nettype none
`include "stall_detect_homing_defines.svh"
module stall_detect_homing
    import sdh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    out_item_t  result;

    // output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;
    logic      out_free;

    // the register can take a result when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    sdh_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: capture, execute; ticks: optional mean update, threshold, judge
    sdh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    sdh_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_data_reg <= result;
    end

    // a stall always ends homing
    `SDH_ASSERT_IMPL(a_stall_ends_homing, aclk, aresetn,
        m_valid && m_data.stall_res, m_data.homing_done && !m_data.homing_active)
    // homing cannot be both running and finished
    `SDH_ASSERT_IMPL(a_flags_exclusive, aclk, aresetn,
        1'b1, !(result.homing_active && result.homing_done))
    // an accepted request keeps the input closed while it is worked on
    `SDH_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready, !s_ready)
    // a result is never loaded over one that has not been taken
    `SDH_ASSERT_IMPL(a_no_overwrite, aclk, aresetn,
        cmd.out_load, !m_valid_reg || m_ready)

endmodule
`default_nettype wire

/* hw/rtl/sdh_cfg_regs.sv */
// configuration register file of the stall detector
`default_nettype none
module sdh_cfg_regs
    import sdh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IGNORE_WINDOW:   cfg_next.ignore_window_ms   = cfg_data[15:0];
                REG_POLL_INTERVAL:   cfg_next.poll_interval_ms   = cfg_data[15:0];
                REG_BASELINE_WINDOW: cfg_next.baseline_window_ms = cfg_data[15:0];
                REG_KEEP_FRACTION:   cfg_next.keep_fraction      = cfg_data[8:0];
                REG_ABS_THRESHOLD:   cfg_next.absolute_threshold = cfg_data[9:0];
                REG_MIN_STALL_STEPS: cfg_next.min_stall_steps    = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{keep_fraction: KEEP_RESET, default: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sdh_ctrl.sv */
// sequencing state machine of the stall detector
`default_nettype none
module sdh_ctrl
    import sdh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       out_free,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 div_last;

    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                if (!status.tick_go) begin
                    state_next = ST_RESULT;
                end else if (status.base_sample) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_THR;
                end
            end
            ST_MUL:    state_next = ST_DINIT;
            ST_DINIT:  state_next = ST_DIV;
            ST_DIV:    if (div_last) state_next = ST_DEND;
            ST_DEND:   state_next = ST_THR;
            ST_THR:    state_next = ST_JUDGE;
            ST_JUDGE:  state_next = ST_RESULT;
            ST_RESULT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC:   cmd.exec = 1'b1;
            ST_MUL:    cmd.mul = 1'b1;
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_DEND:   cmd.div_end = 1'b1;
            ST_THR:    cmd.thr = 1'b1;
            ST_JUDGE:  cmd.judge = 1'b1;
            ST_RESULT: cmd.out_load = out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sdh_datapath.sv */
// homing state, filters, serial divider and stall test
`default_nettype none
module sdh_datapath
    import sdh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  in_item,
    input  wire cfg_t      cfg,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     status,
    output out_item_t      result
);

    // captured request
    in_item_t item_reg;

    // homing state
    logic        active_reg, done_reg, stall_reg;
    logic [31:0] phase_start_reg, last_poll_reg, start_pos_reg;
    logic [15:0] count_reg, baseline_reg, average_reg;

    // work registers
    logic [31:0] prod_reg;
    logic [15:0] rem_reg, quo_reg;
    logic [16:0] thr_reg;
    logic [32:0] travel_reg;

    logic [31:0] since, poll_gap, sum;
    logic        poll_ok, in_base, window_over;
    logic [15:0] sample_word, count_inc;
    logic [18:0] ema_sum;
    logic [16:0] trial;
    logic        trial_ge;
    logic [24:0] scaled_full;
    logic [16:0] scaled, floor_lvl;
    logic [32:0] diff;

    assign since       = item_reg.now_ms - phase_start_reg;
    assign poll_gap    = item_reg.now_ms - last_poll_reg;
    assign poll_ok     = poll_gap >= {16'd0, cfg.poll_interval_ms};
    assign in_base     = since <= {16'd0, cfg.baseline_window_ms};
    assign window_over = since > {16'd0, cfg.ignore_window_ms};
    assign sample_word = {item_reg.load_raw, 6'd0};
    assign count_inc   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 16'd1;
    assign ema_sum     = 19'(3 * {3'd0, average_reg}) + {3'd0, sample_word};
    assign sum         = prod_reg + {16'd0, sample_word};

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[15]};
    assign trial_ge = trial >= {1'b0, count_reg};

    assign scaled_full = baseline_reg * cfg.keep_fraction;
    assign scaled      = scaled_full[24:8];
    assign floor_lvl   = {1'b0, cfg.absolute_threshold, 6'd0};
    assign diff        = {item_reg.position_steps[31], item_reg.position_steps}
                       - {start_pos_reg[31], start_pos_reg};

    assign status.tick_go     = (item_reg.func == FUNC_TICK) && active_reg;
    assign status.base_sample = poll_ok && in_base;

    assign result.stall_res      = stall_reg;
    assign result.homing_active  = active_reg;
    assign result.homing_done    = done_reg;
    assign result.baseline_level = baseline_reg;
    assign result.average_level  = average_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= in_item;
        if (cmd.mul) prod_reg <= baseline_reg * (count_reg - 16'd1);
        if (cmd.div_init) begin
            rem_reg <= sum[31:16];
            quo_reg <= sum[15:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? 16'(trial - {1'b0, count_reg}) : trial[15:0];
            quo_reg <= {quo_reg[14:0], trial_ge};
        end
        if (cmd.thr) begin
            thr_reg    <= (scaled > floor_lvl) ? scaled : floor_lvl;
            travel_reg <= diff[32] ? 33'(-diff) : diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            done_reg        <= 1'b0;
            stall_reg       <= 1'b0;
            phase_start_reg <= '0;
            last_poll_reg   <= '0;
            start_pos_reg   <= '0;
            count_reg       <= '0;
            baseline_reg    <= '0;
            average_reg     <= '0;
        end else begin
            if (cmd.capture) stall_reg <= 1'b0;
            if (cmd.exec) begin
                case (item_reg.func)
                    FUNC_START: begin
                        if (!done_reg && !active_reg) begin
                            active_reg      <= 1'b1;
                            phase_start_reg <= item_reg.now_ms;
                            last_poll_reg   <= '0;
                            start_pos_reg   <= item_reg.position_steps;
                            count_reg       <= '0;
                            baseline_reg    <= '0;
                            average_reg     <= '0;
                        end
                    end
                    FUNC_TICK: begin
                        if (active_reg && poll_ok) begin
                            last_poll_reg <= item_reg.now_ms;
                            if (in_base) begin
                                count_reg <= count_inc;
                            end else begin
                                average_reg <= ema_sum[17:2];
                            end
                        end
                    end
                    FUNC_CLEAR: begin
                        active_reg      <= 1'b0;
                        done_reg        <= 1'b0;
                        phase_start_reg <= '0;
                        last_poll_reg   <= '0;
                        start_pos_reg   <= '0;
                        count_reg       <= '0;
                        baseline_reg    <= '0;
                        average_reg     <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_end) begin
                baseline_reg <= quo_reg;
                if (count_reg < EARLY_FOLLOW) average_reg <= quo_reg;
            end
            if (cmd.judge && window_over && (count_reg > SAMPLES_NEEDED)
                    && ({1'b0, average_reg} <= thr_reg)
                    && (travel_reg >= {9'd0, cfg.min_stall_steps})) begin
                stall_reg  <= 1'b1;
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
